FILE: hw/rtl/vda_pkg.sv
// Shared types, widths and codes for the voxel dose accumulator.
package vda_pkg;

    localparam int unsigned VOXELS_DEF  = 65536;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam int unsigned IDX_W   = 16;
    localparam int unsigned EV_W    = 32;
    localparam int unsigned EN_W    = 32;
    localparam int unsigned WT_W    = 32;
    localparam int unsigned PROD_W  = 64;
    localparam int unsigned SUM_W   = 48;
    localparam int unsigned SQ_W    = 64;
    localparam int unsigned PEND_W  = 40;
    localparam int unsigned HALF_W  = 20;   // half of a pending value for squaring
    localparam int unsigned IN_DATA_W  = 120;
    localparam int unsigned OUT_DATA_W = 184;

    localparam logic [PEND_W-1:0] PEND_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [SQ_W-1:0]   SQ_MAX   = '1;

    // APB register word index
    localparam logic REG_UNC_EN = 1'b0;

    typedef enum logic {
        OP_DEPOSIT = 1'b0,
        OP_READ    = 1'b1
    } t_opcode;

    // one queued transaction; oob marks an index beyond the image
    typedef struct packed {
        t_opcode          op;
        logic             oob;
        logic [IDX_W-1:0] idx;
        logic [EV_W-1:0]  ev;
        logic [EN_W-1:0]  energy;
        logic [WT_W-1:0]  weight;
    } t_item;

    // one voxel entry; sum lands in the lowest bits
    typedef struct packed {
        logic [EV_W-1:0]   last_event;
        logic [PEND_W-1:0] pending;
        logic [SQ_W-1:0]   square;
        logic [SUM_W-1:0]  sum;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_SQ,
        ST_WB
    } t_back_state;

endpackage

FILE: hw/rtl/vda_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vda_ram #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/vda_queue.sv
// Small FIFO between the front classifier and the back sequencer.
module vda_queue #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PW + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (PW + 1)'(DEPTH));
    assign o_empty = (r_count == '0);
endmodule

FILE: hw/rtl/vda_front.sv
// Front end: takes stream transactions, drops dead deposits, tags out-of-image reads.
module vda_front #(
    parameter int unsigned VOXELS = vda_pkg::VOXELS_DEF
) (
    input  logic                           i_s_tvalid,
    input  logic [vda_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_full,
    input  logic                           i_clr_busy,
    output logic                           o_s_tready,
    output logic                           o_push,
    output vda_pkg::t_item                 o_item
);
    import vda_pkg::*;

    localparam logic [24:0] VOX_LIM = 25'(VOXELS);

    logic    w_inside;
    logic    w_in_range;
    logic    w_keep;
    t_opcode w_op;

    always_comb begin
        w_op          = t_opcode'(i_s_tuser);
        o_item.op     = w_op;
        o_item.idx    = i_s_tdata[15:0];
        w_inside      = i_s_tdata[16];
        o_item.ev     = i_s_tdata[48:17];
        o_item.energy = i_s_tdata[80:49];
        o_item.weight = i_s_tdata[112:81];
        w_in_range    = (25'(o_item.idx) < VOX_LIM);
        o_item.oob    = !w_in_range;
        // reads always go through; deposits only when they land in the image
        w_keep        = (w_op == OP_READ) || (w_inside && w_in_range);
        o_s_tready    = !i_clr_busy && !i_full;
        o_push        = i_s_tvalid && o_s_tready && w_keep;
    end
endmodule

FILE: hw/rtl/vda_back.sv
// Back end: post-reset clear sweep and read-modify-write sequencer over the voxel RAM.
module vda_back #(
    parameter int unsigned VOXELS = vda_pkg::VOXELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_unc_en,
    input  logic                           i_empty,
    input  vda_pkg::t_item                 i_item,
    output logic                           o_pop,
    output logic                           o_clr_busy,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [vda_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import vda_pkg::*;

    localparam int unsigned AW = (VOXELS > 1) ? $clog2(VOXELS) : 1;

    t_back_state r_state, n_state;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    t_item               r_item;
    logic [PROD_W-1:0]   r_prod;
    logic [2*HALF_W-1:0] r_hh;
    logic [2*HALF_W-1:0] r_hl;
    logic [2*HALF_W-1:0] r_ll;
    logic [SQ_W-1:0]     r_sq;
    logic [SUM_W-1:0]    r_w;
    logic                r_out_valid;
    t_entry              r_out;

    t_entry        w_rd;
    t_entry        w_new;
    logic          w_wb_we;
    logic          w_load_out;
    logic          w_ram_we;
    logic [AW-1:0] w_waddr;
    t_entry        w_wdata;
    logic          w_same_ev;
    logic [SUM_W-1:0]  w_sum_inc;
    logic [SUM_W:0]    w_sum_ext;
    logic [SQ_W:0]     w_sq_ext;
    logic [SUM_W:0]    w_pend_ext;

    vda_ram #(
        .W     ($bits(t_entry)),
        .DEPTH (VOXELS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (o_pop),
        .i_raddr (AW'(i_item.idx)),
        .o_rdata (w_rd)
    );

    // clear sweep, one entry per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(VOXELS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_wb_we    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!r_clr_busy && !i_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_SQ;
            end
            ST_SQ: begin
                n_state = ST_WB;
            end
            ST_WB: begin
                if (r_item.op == OP_READ) begin
                    if (!r_out_valid) begin
                        w_load_out = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    w_wb_we = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath: product and square partials, then square sum and scaled weight
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_state == ST_RD) begin
            r_prod <= PROD_W'(r_item.energy) * PROD_W'(r_item.weight);
            r_hh   <= w_rd.pending[PEND_W-1:HALF_W] * w_rd.pending[PEND_W-1:HALF_W];
            r_hl   <= w_rd.pending[PEND_W-1:HALF_W] * w_rd.pending[HALF_W-1:0];
            r_ll   <= w_rd.pending[HALF_W-1:0] * w_rd.pending[HALF_W-1:0];
        end
        if (r_state == ST_SQ) begin
            r_sq <= (SQ_W'(r_hh) << 24) + (SQ_W'(r_hl) << 5) + SQ_W'(r_ll >> 16);
            r_w  <= r_prod[PROD_W-1:16];
        end
    end

    // merge of the new deposit into the stored entry
    always_comb begin
        w_new      = w_rd;
        w_same_ev  = (w_rd.last_event == r_item.ev);
        w_sum_inc  = '0;
        if (i_unc_en) begin
            if (!w_same_ev) begin
                w_sum_inc = SUM_W'(w_rd.pending);
            end
        end else begin
            w_sum_inc = r_w;
        end
        w_sum_ext  = (SUM_W + 1)'(w_rd.sum) + (SUM_W + 1)'(w_sum_inc);
        w_sq_ext   = (SQ_W + 1)'(w_rd.square) + (SQ_W + 1)'(r_sq);
        w_pend_ext = (SUM_W + 1)'(w_rd.pending) + (SUM_W + 1)'(r_w);
        w_new.sum  = w_sum_ext[SUM_W] ? SUM_MAX : w_sum_ext[SUM_W-1:0];
        if (i_unc_en) begin
            w_new.last_event = r_item.ev;
            if (w_same_ev) begin
                w_new.pending = (|w_pend_ext[SUM_W:PEND_W]) ? PEND_MAX
                                                            : w_pend_ext[PEND_W-1:0];
            end else begin
                w_new.square  = w_sq_ext[SQ_W] ? SQ_MAX : w_sq_ext[SQ_W-1:0];
                w_new.pending = (|r_w[SUM_W-1:PEND_W]) ? PEND_MAX : r_w[PEND_W-1:0];
            end
        end
    end

    always_comb begin
        w_ram_we = r_clr_busy || w_wb_we;
        w_waddr  = r_clr_busy ? r_clr_addr : AW'(r_item.idx);
        w_wdata  = r_clr_busy ? '0 : w_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= r_item.oob ? '0 : w_rd;
        end
    end

    assign o_clr_busy = r_clr_busy;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;
endmodule

FILE: hw/rtl/voxel_dose_accumulator.sv
// Voxel dose accumulator top level: stream front end, decoupling queue, RMW back end, APB.
// An accepted read passes the queue and back-end states IDLE (pop, RAM read), RD, SQ and WB,
//   which loads the output register once free; the back end handles one transaction at a time
//   (read, multiply, square, write back over the single voxel RAM); a 4-deep queue absorbs
//   bursts; dropped deposits skip the back end. Reset: synchronous, active low; then a clear
//   sweep zeroes all VOXELS entries, one per cycle, s_tready low; APB writes taken throughout.
module voxel_dose_accumulator #(
    parameter int unsigned VOXELS = vda_pkg::VOXELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] voxel_index, [16] inside_req, [48:17] event tag,
    // [80:49] energy_deposit, [112:81] track_weight, [119:113] zero
    input  logic [vda_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] opcode
    input  logic                           s_tuser,
    // master stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [47:0] dose_sum, [111:48] dose_square_sum, [151:112] pending_energy,
    // [183:152] last_event
    output logic [vda_pkg::OUT_DATA_W-1:0] m_tdata,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import vda_pkg::*;

    logic   r_unc_en;
    logic   w_cfg_we;

    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;
    logic   w_clr_busy;
    t_item  w_push_item;
    t_item  w_head_item;

    // config register: uncertainty enable at word 0
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_UNC_EN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unc_en <= 1'b0;
        end else if (w_cfg_we) begin
            r_unc_en <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_UNC_EN) ? {31'b0, r_unc_en} : 32'b0;

    // front: classify and enqueue
    vda_front #(
        .VOXELS (VOXELS)
    ) u_front (
        .i_s_tvalid (s_tvalid),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_full     (w_full),
        .i_clr_busy (w_clr_busy),
        .o_s_tready (s_tready),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    // decoupling queue; front and back stall independently
    vda_queue #(
        .W     ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .i_pop   (w_pop),
        .o_data  (w_head_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // back: RMW over the voxel stores, output register
    vda_back #(
        .VOXELS (VOXELS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_unc_en   (r_unc_en),
        .i_empty    (w_empty),
        .i_item     (w_head_item),
        .o_pop      (w_pop),
        .o_clr_busy (w_clr_busy),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // clear sweep always starts right after reset
    a_clr_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> w_clr_busy)
        else $error("clear sweep not running after reset");

    // no transaction taken while the stores are being cleared
    a_no_accept_in_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !(s_tvalid && s_tready))
        else $error("transaction accepted during clear sweep");

    // queue never pushed when full
    a_queue_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue overflow");

    // nothing is popped during the clear sweep
    a_no_pop_in_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !w_pop)
        else $error("queue popped during clear sweep");

endmodule
